// File: rtl/core/cbm_pkg.sv
// Shared types, codes and reset constants of the cell balance monitor slave.
package cbm_pkg;

   // configuration register indexes
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_INIT_ADDR = 1'b1;

   localparam logic [9:0] THRESHOLD_RESET = 10'd860;
   localparam logic [7:0] ADDRESS_RESET   = 8'd3;

   // command codes
   localparam logic [7:0] CMD_SET_ADDR    = 8'h10;
   localparam logic [7:0] CMD_READOUT     = 8'h20;
   localparam logic [3:0] CMD_OFFSET      = 4'h3;   // high nibble, low nibble is the cell
   localparam logic [7:0] CMD_SET_MONITOR = 8'h40;
   localparam logic [7:0] CMD_CONVERT     = 8'h50;
   localparam logic [7:0] CMD_NONE        = 8'h00;

   localparam logic [15:0] SYNC_WORD = 16'hFFFF;

   // result limit per item, in two-byte words
   localparam int unsigned MAX_WORDS = 5;

   typedef struct packed {
      logic       run;
      logic [7:0] code;
      logic [7:0] data;
   } cbm_cmd_type;

   typedef struct packed {
      logic monitor_on;
      logic conversion_on;
   } cbm_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_FRAME,
      ST_FETCH,
      ST_CAPTURE,
      ST_EMIT_LO,
      ST_EMIT_HI,
      ST_EMIT_NONE
   } cbm_state_type;

   // offset of a cell after reset
   function automatic logic [7:0] cbm_offset_init(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'd9;
         4'd1:    val = 8'd7;
         4'd2:    val = 8'hF6;
         4'd3:    val = 8'd14;
         4'd4:    val = 8'd4;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/cbm_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module cbm_ram
#(
   parameter int unsigned DEPTH  = 5,
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cbm_frame_dec.sv
// Nine-bit serial frame protocol: address match, command, argument, mode flags.
module cbm_frame_dec
   import cbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         frame_strobe,
   input  logic         ninth_bit,
   input  logic [7:0]   rx_byte,
   input  logic         addr_load,
   input  logic [7:0]   addr_value,
   output cbm_cmd_type  cmd,
   output cbm_mode_type mode
);

   logic [7:0]   address_ff, address_in;
   logic         listening_ff, listening_in;
   logic [7:0]   pending_ff, pending_in;
   cbm_mode_type mode_ff, mode_in;
   cbm_cmd_type  cmd_ff, cmd_in;

   always_comb begin
      address_in   = address_ff;
      listening_in = listening_ff;
      pending_in   = pending_ff;
      mode_in      = mode_ff;
      cmd_in       = '{run: 1'b0, code: pending_ff, data: rx_byte};
      if (frame_strobe) begin
         if (ninth_bit) begin
            if (rx_byte == address_ff) begin
               listening_in = 1'b1;
            end
         end else if (listening_ff) begin
            if (pending_ff != CMD_NONE) begin
               listening_in = 1'b0;
               pending_in   = CMD_NONE;
               cmd_in.run   = 1'b1;
               if (pending_ff == CMD_SET_ADDR) begin
                  address_in = rx_byte;
               end
               if (pending_ff == CMD_SET_MONITOR) begin
                  mode_in.monitor_on = (rx_byte != 8'd0);
               end
               if (pending_ff == CMD_CONVERT) begin
                  mode_in.conversion_on = (rx_byte != 8'd0);
               end
            end else begin
               pending_in = rx_byte;
            end
         end
      end
      if (addr_load) begin
         address_in = addr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= ADDRESS_RESET;
         listening_ff <= 1'b0;
         pending_ff   <= CMD_NONE;
         mode_ff      <= '{monitor_on: 1'b0, conversion_on: 1'b1};
         cmd_ff       <= '0;
      end else begin
         address_ff   <= address_in;
         listening_ff <= listening_in;
         pending_ff   <= pending_in;
         mode_ff      <= mode_in;
         cmd_ff       <= cmd_in;
      end
   end

   assign cmd  = cmd_ff;
   assign mode = mode_ff;

endmodule

// File: rtl/core/cell_balance_monitor_slave_core.sv
// Top level of the cell balance monitor slave: sequencer, stores and result register.
//
// Usage notes
//  - req_ channel: one word per item. req_operation 0 is a cell sample
//    (req_cell_index, req_adc_value), 1 is a received serial frame
//    (req_ninth_bit, req_rx_byte). One item is worked on at a time;
//    req_ready is high only while the sequencer is idle.
//  - rsp_ channel: one or more words per item, rsp_last marks the final one.
//    An item with nothing to transmit yields a single word with
//    rsp_tx_valid low. rsp_discharge_levels carries the pin levels after the item.
//  - Order: a sample is written to the reading store, then its bytes, if any,
//    are sent; a readout command steps through fetch, capture and two bytes
//    per stored reading.
//    The readout is paced by the single read port of the reading store.
//  - csr_ port: writes take effect at once and are to be made while idle
//    by the user; the block itself does not enforce this.
//  - Reset clears the sequencer, mode flags, protocol state, pin levels
//    (all discharge off) and the store valid bits; stores read back their
//    reset values until written. No clearing pass is needed.
//  - A stalled receiver holds the result register; the sequencer waits.
module cell_balance_monitor_slave_core
   import cbm_pkg::*;
#(
   parameter int unsigned CELL_COUNT = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   // sample / frame words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [2:0]            req_cell_index,
   input  logic [9:0]            req_adc_value,
   input  logic                  req_ninth_bit,
   input  logic [7:0]            req_rx_byte,
   // transmit words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_tx_valid,
   output logic [7:0]            rsp_tx_byte,
   output logic [CELL_COUNT-1:0] rsp_discharge_levels,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [9:0]            csr_wdata
);

   localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam logic [4:0] CELL_LIMIT = 5'(CELL_COUNT);
   localparam logic [2:0] READ_WORDS =
      3'((CELL_COUNT < MAX_WORDS) ? CELL_COUNT : MAX_WORDS);
   localparam logic [CELL_COUNT-1:0] PIN_RESET = ~CELL_COUNT'(1);

   cbm_state_type state_ff, state_in;

   // protocol unit
   cbm_cmd_type  cmd;
   cbm_mode_type mode;
   logic         frame_strobe;
   logic         addr_load;

   // stores
   logic          ofs_rd_en, ofs_wr_en, rdg_rd_en, rdg_wr_en;
   logic [AW-1:0] ofs_rd_addr, ofs_wr_addr, rdg_rd_addr, rdg_wr_addr;
   logic [7:0]    ofs_q;
   logic [15:0]   rdg_q;
   logic [AW-1:0] ofs_addr_ff, rdg_addr_ff;
   logic [CELL_COUNT-1:0] ofs_valid_ff, rdg_valid_ff;
   logic [4:0]    ofs_addr_wide;
   logic [7:0]    ofs_word;
   logic [15:0]   rdg_word;

   // datapath
   logic [9:0]    threshold_ff;
   logic [4:0]    sample_idx_ff;
   logic [9:0]    adc_ff;
   logic [15:0]   sample_sum;
   logic          over;
   logic [15:0]   sample_word_ff;
   logic [15:0]   word_ff;
   logic [2:0]    wcnt_ff, nwords_ff;
   logic [4:0]    wcnt_wide;
   logic          readout_ff;
   logic          last_word;
   logic [CELL_COUNT-1:0] pins_ff;

   // input decode
   logic          req_accept;
   logic [4:0]    idx_wide;
   logic          sample_ok;
   logic [4:0]    ofs_cmd_idx;
   logic          ofs_cmd;

   // result register
   logic                  out_free, out_load;
   logic                  out_tx_valid, out_last;
   logic [7:0]            out_byte;
   logic                  rsp_valid_ff;
   logic                  rsp_tx_valid_ff;
   logic [7:0]            rsp_tx_byte_ff;
   logic [CELL_COUNT-1:0] rsp_levels_ff;
   logic                  rsp_last_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign idx_wide   = {2'b00, req_cell_index};
   assign sample_ok  = mode.conversion_on && (idx_wide < CELL_LIMIT);

   assign frame_strobe = req_accept & req_operation;
   assign addr_load    = csr_we && (csr_index == CSR_INIT_ADDR);

   cbm_frame_dec u_frame_dec (
      .clock        (clock),
      .reset        (reset),
      .frame_strobe (frame_strobe),
      .ninth_bit    (req_ninth_bit),
      .rx_byte      (req_rx_byte),
      .addr_load    (addr_load),
      .addr_value   (csr_wdata[7:0]),
      .cmd          (cmd),
      .mode         (mode)
   );

   // offset command names a cell in the low nibble
   assign ofs_cmd_idx = {1'b0, cmd.code[3:0]};
   assign ofs_cmd     = cmd.run && (cmd.code[7:4] == CMD_OFFSET) && (ofs_cmd_idx < CELL_LIMIT);

   // store reads: unwritten entries return their reset values
   assign ofs_addr_wide = 5'(ofs_addr_ff);
   assign ofs_word = ofs_valid_ff[ofs_addr_ff] ? ofs_q : cbm_offset_init(ofs_addr_wide[3:0]);
   assign rdg_word = rdg_valid_ff[rdg_addr_ff] ? rdg_q : 16'd0;

   // reading = raw + signed offset, 16-bit wrap
   assign sample_sum = {6'd0, adc_ff} + {{8{ofs_word[7]}}, ofs_word};
   assign over       = sample_sum > {6'd0, threshold_ff};

   assign wcnt_wide = {2'b00, wcnt_ff};
   assign last_word = (wcnt_ff == (nwords_ff - 3'd1));
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   cbm_ram #(.DEPTH(CELL_COUNT), .WIDTH(8)) u_offset_ram (
      .clock   (clock),
      .wr_en   (ofs_wr_en),
      .wr_addr (ofs_wr_addr),
      .wr_data (cmd.data),
      .rd_en   (ofs_rd_en),
      .rd_addr (ofs_rd_addr),
      .rd_data (ofs_q)
   );

   cbm_ram #(.DEPTH(CELL_COUNT), .WIDTH(16)) u_reading_ram (
      .clock   (clock),
      .wr_en   (rdg_wr_en),
      .wr_addr (rdg_wr_addr),
      .wr_data (sample_sum),
      .rd_en   (rdg_rd_en),
      .rd_addr (rdg_rd_addr),
      .rd_data (rdg_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation) begin
                  state_in = ST_FRAME;
               end else if (sample_ok) begin
                  state_in = ST_SAMPLE;
               end else begin
                  state_in = ST_EMIT_NONE;
               end
            end
         end
         ST_SAMPLE: begin
            state_in = mode.monitor_on ? ST_EMIT_LO : ST_EMIT_NONE;
         end
         ST_FRAME: begin
            state_in = (cmd.run && (cmd.code == CMD_READOUT)) ? ST_FETCH : ST_EMIT_NONE;
         end
         ST_FETCH:   state_in = ST_CAPTURE;
         ST_CAPTURE: state_in = ST_EMIT_LO;
         ST_EMIT_LO: begin
            if (out_free) begin
               state_in = ST_EMIT_HI;
            end
         end
         ST_EMIT_HI: begin
            if (out_free) begin
               if (last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = readout_ff ? ST_FETCH : ST_EMIT_LO;
               end
            end
         end
         ST_EMIT_NONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ofs_rd_en    = 1'b0;
      ofs_wr_en    = 1'b0;
      rdg_rd_en    = 1'b0;
      rdg_wr_en    = 1'b0;
      ofs_rd_addr  = idx_wide[AW-1:0];
      ofs_wr_addr  = ofs_cmd_idx[AW-1:0];
      rdg_rd_addr  = wcnt_wide[AW-1:0];
      rdg_wr_addr  = sample_idx_ff[AW-1:0];
      out_load     = 1'b0;
      out_tx_valid = 1'b1;
      out_byte     = 8'd0;
      out_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE:    ofs_rd_en = req_accept && !req_operation && sample_ok;
         ST_SAMPLE:  rdg_wr_en = 1'b1;
         ST_FRAME:   ofs_wr_en = ofs_cmd;
         ST_FETCH:   rdg_rd_en = 1'b1;
         ST_CAPTURE: ;
         ST_EMIT_LO: begin
            out_load = out_free;
            out_byte = word_ff[7:0];
         end
         ST_EMIT_HI: begin
            out_load = out_free;
            out_byte = word_ff[15:8];
            out_last = last_word;
         end
         ST_EMIT_NONE: begin
            out_load     = out_free;
            out_tx_valid = 1'b0;
            out_last     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         ofs_valid_ff <= '0;
         rdg_valid_ff <= '0;
         pins_ff      <= PIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && (csr_index == CSR_THRESHOLD)) begin
            threshold_ff <= csr_wdata;
         end
         if (ofs_wr_en) begin
            ofs_valid_ff[ofs_wr_addr] <= 1'b1;
         end
         if (rdg_wr_en) begin
            rdg_valid_ff[rdg_wr_addr] <= 1'b1;
            for (int i = 0; i < CELL_COUNT; i++) begin
               if (sample_idx_ff == 5'(i)) begin
                  // cell 0 drives high to discharge, the others low
                  pins_ff[i] <= ((i == 0) == over);
               end
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ofs_rd_en) begin
         ofs_addr_ff <= ofs_rd_addr;
      end
      if (rdg_rd_en) begin
         rdg_addr_ff <= rdg_rd_addr;
      end
      if (req_accept) begin
         sample_idx_ff <= idx_wide;
         adc_ff        <= req_adc_value;
      end
      unique case (state_ff)
         ST_SAMPLE: begin
            sample_word_ff <= sample_sum;
            readout_ff     <= 1'b0;
            wcnt_ff        <= 3'd0;
            if (sample_idx_ff == 5'd0) begin
               word_ff   <= SYNC_WORD;
               nwords_ff <= 3'd2;
            end else begin
               word_ff   <= sample_sum;
               nwords_ff <= 3'd1;
            end
         end
         ST_FRAME: begin
            readout_ff <= 1'b1;
            wcnt_ff    <= 3'd0;
            nwords_ff  <= READ_WORDS;
         end
         ST_CAPTURE: word_ff <= rdg_word;
         ST_EMIT_HI: begin
            if (out_free && !last_word) begin
               wcnt_ff <= wcnt_ff + 3'd1;
               if (!readout_ff) begin
                  word_ff <= sample_word_ff;
               end
            end
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_tx_valid_ff <= out_tx_valid;
         rsp_tx_byte_ff  <= out_byte;
         rsp_levels_ff   <= pins_ff;
         rsp_last_ff     <= out_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tx_valid         = rsp_tx_valid_ff;
   assign rsp_tx_byte          = rsp_tx_byte_ff;
   assign rsp_discharge_levels = rsp_levels_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for cell_balance_monitor_slave_core: directed rows, then random traffic.
module tb_top;
   import cbm_pkg::*;

   localparam int CELLS      = 5;
   localparam int BYTE_LIMIT = 2 * MAX_WORDS;   // transmit bytes kept per request word

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_FRAME   = 1'b1;
   localparam logic FRAME_DATA = 1'b0;
   localparam logic FRAME_ADDR = 1'b1;

   typedef struct packed {
      logic       op;
      logic [2:0] cell_idx;
      logic [9:0] adc;
      logic       ninth;
      logic [7:0] rx;
   } req_item_t;

   typedef struct packed {
      logic             tx_valid;
      logic [7:0]       tx_byte;
      logic [CELLS-1:0] levels;
      logic             last;
   } tx_word_t;

   // fixed = 1: single idle word with the given pin levels, typed in by hand
   typedef struct packed {
      req_item_t        item;
      logic             fixed;
      logic [CELLS-1:0] levels;
   } dir_row_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_operation = OP_SAMPLE;
   logic [2:0]       req_cell_index = '0;
   logic [9:0]       req_adc_value = '0;
   logic             req_ninth_bit = FRAME_DATA;
   logic [7:0]       req_rx_byte = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_tx_valid;
   logic [7:0]       rsp_tx_byte;
   logic [CELLS-1:0] rsp_discharge_levels;
   logic             rsp_last;
   logic             csr_we = 1'b0;
   logic             csr_index = CSR_THRESHOLD;
   logic [9:0]       csr_wdata = '0;

   cell_balance_monitor_slave_core #(.CELL_COUNT(CELLS)) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_cell_index       (req_cell_index),
      .req_adc_value        (req_adc_value),
      .req_ninth_bit        (req_ninth_bit),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_tx_valid         (rsp_tx_valid),
      .rsp_tx_byte          (rsp_tx_byte),
      .rsp_discharge_levels (rsp_discharge_levels),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Monitor state as the block should hold it; initial values = reset
   // ------------------------------------------------------------------
   logic [15:0]      m_reading [CELLS] = '{default: 16'd0};
   logic [7:0]       m_offset  [CELLS] = '{8'd9, 8'd7, 8'hF6, 8'd14, 8'd4};
   logic [9:0]       m_thresh  = THRESHOLD_RESET;
   logic [7:0]       m_addr    = ADDRESS_RESET;
   logic             m_listen  = 1'b0;
   logic [7:0]       m_cmd     = CMD_NONE;
   logic             m_monitor = 1'b0;
   logic             m_convert = 1'b1;
   logic [CELLS-1:0] m_pins    = 5'b11110;   // every discharge switch off

   logic [7:0]       tx_bytes [BYTE_LIMIT];
   int               tx_count;

   tx_word_t         tx_expected [$];   // transmit words still owed by the block

   int               err_count     = 0;
   int               words_seen    = 0;
   int               items_sent    = 0;
   int               items_acting  = 0;
   bit               tx_quiet      = 1'b0;   // sender runs back to back while set
   bit               rx_quiet      = 1'b0;   // receiver never stalls while set

   // Directed rows: extremes, offset wrap, ignored samples, protocol corners.
   dir_row_t dir_rows [25] = '{
      '{'{OP_SAMPLE, 3'd0, 10'd0,    FRAME_DATA, 8'h00}, 1'b1, 5'd30},  // 9, below
      '{'{OP_SAMPLE, 3'd0, 10'd1023, FRAME_DATA, 8'h00}, 1'b1, 5'd31},  // cell 0 on
      '{'{OP_SAMPLE, 3'd2, 10'd0,    FRAME_DATA, 8'h00}, 1'b1, 5'd27},  // wraps to FFF6
      '{'{OP_SAMPLE, 3'd4, 10'd1023, FRAME_DATA, 8'h00}, 1'b1, 5'd11},
      '{'{OP_SAMPLE, 3'd7, 10'd1023, FRAME_DATA, 8'h00}, 1'b1, 5'd11},  // no such cell
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_SET_MONITOR}, 1'b1, 5'd11},  // not listening
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'h04},         1'b1, 5'd11},  // other slave
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'h03},         1'b1, 5'd11},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_NONE},      1'b1, 5'd11},  // zero command
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_READOUT},   1'b1, 5'd11},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, 8'h55},         1'b0, 5'd0},   // ten bytes
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'h03},         1'b1, 5'd11},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_SET_MONITOR}, 1'b1, 5'd11},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, 8'h01},         1'b1, 5'd11},
      '{'{OP_SAMPLE, 3'd0, 10'd851,  FRAME_DATA, 8'h00},      1'b0, 5'd0},   // 860, sync
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'h03},         1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, {CMD_OFFSET, 4'd5}}, 1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, 8'h77},         1'b1, 5'd10},  // bad index
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'h03},         1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_SET_ADDR},  1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, 8'hFF},         1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_ADDR, 8'hFF},         1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, CMD_CONVERT},   1'b1, 5'd10},
      '{'{OP_FRAME,  3'd0, 10'd0, FRAME_DATA, 8'h00},         1'b1, 5'd10},  // conversion off
      '{'{OP_SAMPLE, 3'd1, 10'd1023, FRAME_DATA, 8'h00},      1'b1, 5'd10}   // ignored
   };

   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop, well past the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Append a 16-bit reading to the transmit bytes, low byte first; excess is dropped.
   function automatic void queue_reading(input logic [15:0] w);
      for (int k = 0; k < 2; k++) begin
         if (tx_count < BYTE_LIMIT) begin
            tx_bytes[tx_count] = w[8*k +: 8];
            tx_count++;
         end
      end
   endfunction

   // Advance the monitor state by one request word and collect the bytes it sends.
   // Returns 1 when the word acts on the block rather than being ignored.
   function automatic bit predict_item(input req_item_t it);
      logic [15:0] v;
      logic [7:0]  code;
      bit          acted;
      acted    = 1'b0;
      tx_count = 0;
      if (it.op == OP_SAMPLE) begin
         if (m_convert && it.cell_idx < CELLS) begin
            acted = 1'b1;
            // signed offset, 16-bit wrap
            v = 16'(it.adc) + {{8{m_offset[it.cell_idx][7]}}, m_offset[it.cell_idx]};
            m_reading[it.cell_idx] = v;
            // cell 0 switch is active high, the others active low
            m_pins[it.cell_idx] = ((it.cell_idx == 3'd0) == (v > 16'(m_thresh)));
            if (m_monitor) begin
               if (it.cell_idx == 3'd0) queue_reading(SYNC_WORD);
               queue_reading(v);
            end
         end
      end else if (it.ninth == FRAME_ADDR) begin
         // a match opens listening and keeps any pending command
         acted = (it.rx == m_addr);
         if (acted) m_listen = 1'b1;
      end else if (m_listen) begin
         acted = 1'b1;
         if (m_cmd == CMD_NONE) begin
            m_cmd = it.rx;   // zero here leaves the next data frame a command again
         end else begin
            code     = m_cmd;
            m_listen = 1'b0;
            m_cmd    = CMD_NONE;
            if (code == CMD_SET_ADDR) m_addr = it.rx;
            if (code[7:4] == CMD_OFFSET && code[3:0] < CELLS) m_offset[code[3:0]] = it.rx;
            if (code == CMD_READOUT) begin
               for (int i = 0; i < CELLS; i++) queue_reading(m_reading[i]);
            end
            if (code == CMD_SET_MONITOR) m_monitor = (it.rx != 8'h00);
            if (code == CMD_CONVERT) m_convert = (it.rx != 8'h00);
         end
      end
      return acted;
   endfunction

   function automatic req_item_t rand_item();
      req_item_t r;
      r.op       = 1'($urandom_range(0, 1));
      r.cell_idx = 3'($urandom_range(0, 7));
      r.adc      = 10'($urandom_range(0, 1023));
      r.ninth    = 1'($urandom_range(0, 1));
      r.rx       = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Present one request word after a random gap and hold it until accepted.
   task automatic drive_req(input req_item_t it);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation  <= it.op;
      req_cell_index <= it.cell_idx;
      req_adc_value  <= it.adc;
      req_ninth_bit  <= it.ninth;
      req_rx_byte    <= it.rx;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      if (items_sent % 30 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
   endtask

   // Send a word, update the monitor state and queue the transmit words it owes.
   task automatic issue(input req_item_t it, input logic fixed,
                        input logic [CELLS-1:0] fixed_levels, output bit acted);
      drive_req(it);
      acted = predict_item(it);
      if (acted) items_acting++;
      if (fixed) begin
         tx_expected.push_back(tx_word_t'{1'b0, 8'h00, fixed_levels, 1'b1});
      end else if (tx_count == 0) begin
         tx_expected.push_back(tx_word_t'{1'b0, 8'h00, m_pins, 1'b1});
      end else begin
         for (int k = 0; k < tx_count; k++)
            tx_expected.push_back(tx_word_t'{1'b1, tx_bytes[k], m_pins, k == tx_count - 1});
      end
   endtask

   task automatic send_frame(input logic ninth, input logic [7:0] rx, inout int done);
      req_item_t it;
      bit        acted;
      it       = rand_item();
      it.op    = OP_FRAME;
      it.ninth = ninth;
      it.rx    = rx;
      issue(it, 1'b0, '0, acted);
      done += int'(acted);
   endtask

   // Sender holds off until every owed word is back, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (tx_expected.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [9:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_THRESHOLD) m_thresh = data;
      else m_addr = data[7:0];   // address register also reloads the live address
   endtask

   // Mostly well-formed address/command/argument exchanges and samples,
   // with some loose frames and broken exchanges mixed in.
   task automatic random_traffic(input int target);
      int          done;
      int          t;
      bit          acted;
      req_item_t   it;
      logic [7:0]  code;
      logic [7:0]  arg;
      done = 0;
      while (done < target) begin
         t = $urandom_range(0, 99);
         if (t < 45) begin
            it    = rand_item();
            it.op = OP_SAMPLE;
            it.cell_idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
            // land close to the threshold now and then
            if (it.cell_idx < CELLS && $urandom_range(0, 3) == 0) begin
               t = int'(m_thresh) - int'($signed(m_offset[it.cell_idx]))
                   + int'($urandom_range(0, 6)) - 3;
               it.adc = 10'((t < 0) ? 0 : (t > 1023) ? 1023 : t);
            end
            issue(it, 1'b0, '0, acted);
            done += int'(acted);
         end else if (t < 87) begin
            case ($urandom_range(0, 9))
               0:       code = CMD_SET_ADDR;
               1, 2:    code = CMD_READOUT;
               3, 4:    code = {CMD_OFFSET, ($urandom_range(0, 4) == 0)
                                ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4))};
               5:       code = CMD_SET_MONITOR;
               6:       code = CMD_CONVERT;
               7:       code = 8'($urandom_range(0, 255));
               default: code = m_convert ? CMD_SET_MONITOR : CMD_CONVERT;
            endcase
            arg = 8'($urandom_range(0, 255));
            if (code == CMD_SET_MONITOR && $urandom_range(0, 1) == 0) arg = 8'h00;
            if (code == CMD_CONVERT)
               arg = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            // now and then the address frame is missing or repeated mid-exchange
            if ($urandom_range(0, 9) != 0) send_frame(FRAME_ADDR, m_addr, done);
            send_frame(FRAME_DATA, code, done);
            if ($urandom_range(0, 9) == 0) send_frame(FRAME_ADDR, m_addr, done);
            send_frame(FRAME_DATA, arg, done);
         end else begin
            it    = rand_item();
            it.op = OP_FRAME;
            issue(it, 1'b0, '0, acted);
            done += int'(acted);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall before each transmit word, with quiet stretches
   // ------------------------------------------------------------------
   initial begin : rsp_pacer
      int hold;
      int taken;
      taken = 0;
      @(posedge clock);
      forever begin
         hold = rx_quiet ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
         if (taken % 25 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // ------------------------------------------------------------------
   // Checker: every accepted transmit word against the oldest owed word
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      tx_word_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         words_seen++;
         if (tx_expected.size() == 0) begin
            $error("transmit word with none owed: tx_valid %0d tx_byte %h",
                   rsp_tx_valid, rsp_tx_byte);
            err_count++;
         end else begin
            want = tx_expected.pop_front();
            if (rsp_tx_valid !== want.tx_valid) begin
               $error("tx_valid: expected %0d, got %0d", want.tx_valid, rsp_tx_valid);
               err_count++;
            end
            if (rsp_tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_tx_byte);
               err_count++;
            end
            if (rsp_discharge_levels !== want.levels) begin
               $error("discharge_levels: expected %b, got %b",
                      want.levels, rsp_discharge_levels);
               err_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      bit         acted;
      logic [9:0] thr;
      logic [7:0] adr;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows with reset register values
      foreach (dir_rows[i])
         issue(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].levels, acted);

      // one register setting per phase: both floors, both ceilings, random, reset values
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0:       begin thr = 10'd0;    adr = 8'h00; end
            1:       begin thr = 10'd1023; adr = 8'hFF; end
            2:       begin
               thr = 10'($urandom_range(1, 1022));
               adr = 8'($urandom_range(1, 254));
            end
            default: begin thr = THRESHOLD_RESET; adr = ADDRESS_RESET; end
         endcase
         write_csr(CSR_THRESHOLD, thr);
         write_csr(CSR_INIT_ADDR, {2'b00, adr});
         csr_we <= 1'b0;
         if (ph == 0) begin
            // sender waits mid-phase for the block to empty out
            random_traffic(50);
            drain();
            random_traffic(50);
         end else begin
            random_traffic(100);
         end
      end

      drain();
      $display("covered %0d request words (%0d acting on the block), %0d transmit words checked",
               items_sent, items_acting, words_seen);
      $display("across reset values and four threshold/address settings");
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_ram.sv
rtl/core/cbm_frame_dec.sv
rtl/core/cell_balance_monitor_slave_core.sv
dv/tb_top.sv
